/* hw/rtl/fag_pkg.sv */
// Shared types and constants of the font atlas glyph lookup.
package fag_pkg;

	localparam int UV_FRAC_BITS = 16;
	localparam int UV_W         = UV_FRAC_BITS + 1;
	localparam int REG9_W       = 9;
	localparam int SIZE_W       = 13;
	localparam int CP_W         = 21;
	localparam int SLOT_W       = 8;
	localparam int STATUS_W     = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 13;
	// dividend of the serial divider: a 9-bit value shifted up by the fraction bits
	localparam int DIV_W        = REG9_W + UV_FRAC_BITS;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 3'd4;

	localparam logic [STATUS_W-1:0] ST_FOUND       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BEYOND_GRID = 2'd2;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef struct packed {
		logic              action;
		logic [SLOT_W-1:0] slot;
		logic [CP_W-1:0]   codepoint;
	} cmd_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [UV_W-1:0]     uv_left;
		logic [UV_W-1:0]     uv_right;
		logic [UV_W-1:0]     uv_top;
		logic [UV_W-1:0]     uv_bottom;
		logic [SIZE_W-1:0]   out_width;
		logic [SIZE_W-1:0]   out_height;
	} res_item_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
	} tok_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  dividend;
		logic [REG9_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quot;
		logic [REG9_W-1:0] rem;
	} div_rsp_t;

endpackage

/* hw/rtl/fag_cell.sv */
// One slot of the codepoint table with its stage of the search chain.
module fag_cell #(
	parameter int IDX_W    = 8,
	parameter int CELL_IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [fag_pkg::SLOT_W-1:0] wr_slot,
	input  logic [fag_pkg::CP_W-1:0]   wr_cp,
	input  logic [fag_pkg::CP_W-1:0]   key,
	input  logic [fag_pkg::REG9_W-1:0] count,
	input  fag_pkg::tok_t             tok_in,
	input  logic [IDX_W-1:0]          idx_in,
	output fag_pkg::tok_t             tok_out,
	output logic [IDX_W-1:0]          idx_out
);
	import fag_pkg::*;

	localparam int CW = (IDX_W > REG9_W) ? IDX_W : REG9_W;
	localparam logic [CW-1:0]    MY_POS = CW'(CELL_IDX);
	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	logic [CP_W-1:0]  entry_q;
	tok_t             tok_q;
	logic [IDX_W-1:0] idx_q;
	logic             match;

	// only slots below the glyph count take part; the first hit wins
	assign match = tok_in.valid && !tok_in.found && (MY_POS < CW'(count)) && (entry_q == key);

	always_ff @(posedge clk) begin
		if (wr_en && (CW'(wr_slot) == MY_POS)) begin
			entry_q <= wr_cp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found | match;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= match ? MY_IDX : idx_in;
	end

	assign tok_out = tok_q;
	assign idx_out = idx_q;

endmodule

/* hw/rtl/fag_div.sv */
// Restoring divider, one quotient bit per cycle, 9-bit divisor.
module fag_div (
	input  logic              clk,
	input  logic              arst_n,
	input  fag_pkg::div_req_t req,
	output fag_pkg::div_rsp_t rsp
);
	import fag_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [REG9_W-1:0] rem_q;
	logic [REG9_W-1:0] dvs_q;
	logic [REG9_W:0]   trial;
	logic [REG9_W:0]   diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[REG9_W-1:0] : trial[REG9_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == CNT_W'(1)) |=> rsp.done)
		else $error("divider missed its done pulse");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("divider done held");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");

endmodule

/* hw/rtl/font_atlas_glyph_lookup_top.sv */
// Font atlas glyph lookup: codepoint cell chain, serial divider and result control.
// Load item: taken whenever no lookup is under way; it gives no result.
// Lookup: the token walks the cell chain, then five divisions run in turn on the shared divider;
//   the result register is loaded once it is free, and the next item is taken back in idle.
// A miss skips the divisions, a row beyond the grid stops after the first one.
// Reset (arst_n low, asynchronous) resets control, result and configuration, not the table.
module font_atlas_glyph_lookup_top #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  fag_pkg::cmd_item_t            cmd,
	// result channel
	output logic                          res_valid,
	input  logic                          res_ready,
	output fag_pkg::res_item_t            res,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [fag_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [fag_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fag_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << UV_FRAC_BITS;
	localparam logic [UV_FRAC_BITS-1:0] FRAC_ZERO = '0;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_SCAN   = 8'b0000_0010,
		S_DIVIDX = 8'b0000_0100,
		S_UVL    = 8'b0000_1000,
		S_UVR    = 8'b0001_0000,
		S_UVT    = 8'b0010_0000,
		S_UVB    = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t            state_q;

	// configuration
	logic [REG9_W-1:0] grid_columns_q;
	logic [REG9_W-1:0] grid_rows_q;
	logic [REG9_W-1:0] glyph_count_q;
	logic [SIZE_W-1:0] glyph_width_q;
	logic [SIZE_W-1:0] glyph_height_q;
	logic [REG9_W-1:0] cols_eff;
	logic [REG9_W-1:0] rows_eff;
	logic [SIZE_W-1:0] width_eff;
	logic [SIZE_W-1:0] height_eff;

	// lookup working registers
	logic [CP_W-1:0]     key_q;
	logic                inj_q;
	logic [STATUS_W-1:0] status_q;
	logic [REG9_W-1:0]   col_q;
	logic [REG9_W-1:0]   row_q;
	logic [REG9_W-1:0]   col_inc;
	logic [REG9_W-1:0]   row_inc;
	logic [UV_W-1:0]     uvl_q;
	logic [UV_W-1:0]     uvr_q;
	logic [UV_W-1:0]     uvt_q;
	logic [UV_W-1:0]     uvb_q;
	logic                beyond;

	// result register
	res_item_t res_q;
	logic      res_valid_q;

	logic      ld_en;
	div_req_t  div_req;
	div_rsp_t  div_rsp;

	tok_t             tok_w [0:TABLE_DEPTH];
	logic [IDX_W-1:0] idx_w [0:TABLE_DEPTH];

	// a zero in a size register counts as one
	assign cols_eff   = (grid_columns_q == '0) ? REG9_W'(1) : grid_columns_q;
	assign rows_eff   = (grid_rows_q == '0) ? REG9_W'(1) : grid_rows_q;
	assign width_eff  = (glyph_width_q == '0) ? SIZE_W'(1) : glyph_width_q;
	assign height_eff = (glyph_height_q == '0) ? SIZE_W'(1) : glyph_height_q;

	assign cmd_ready = (state_q == S_IDLE);
	assign ld_en     = cmd_valid && cmd_ready && (cmd.action == ACT_LOAD);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign col_inc = col_q + 1'b1;
	assign row_inc = row_q + 1'b1;
	// row index is the quotient of slot over columns
	assign beyond  = div_rsp.quot >= DIV_W'(rows_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= REG9_W'(1);
			grid_rows_q    <= REG9_W'(1);
			glyph_count_q  <= '0;
			glyph_width_q  <= SIZE_W'(1);
			glyph_height_q <= SIZE_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_GRID_COLUMNS: grid_columns_q <= cfg_data[REG9_W-1:0];
				CFG_GRID_ROWS:    grid_rows_q    <= cfg_data[REG9_W-1:0];
				CFG_GLYPH_COUNT:  glyph_count_q  <= cfg_data[REG9_W-1:0];
				CFG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data[SIZE_W-1:0];
				CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// search chain: token enters cell 0 from inj_q, registered when the lookup is taken (valid, not found)
	assign tok_w[0] = {inj_q, 1'b0};
	assign idx_w[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		fag_cell #(
			.IDX_W   (IDX_W),
			.CELL_IDX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr_en  (ld_en),
			.wr_slot(cmd.slot),
			.wr_cp  (cmd.codepoint),
			.key    (key_q),
			.count  (glyph_count_q),
			.tok_in (tok_w[i]),
			.idx_in (idx_w[i]),
			.tok_out(tok_w[i+1]),
			.idx_out(idx_w[i+1])
		);
	end

	fag_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// divider sequencing: slot split first, then the four coordinates
	always_comb begin
		div_req          = '0;
		div_req.divisor  = cols_eff;
		case (state_q)
			S_SCAN: begin
				if (tok_w[TABLE_DEPTH].valid && tok_w[TABLE_DEPTH].found) begin
					div_req.start    = 1'b1;
					div_req.dividend = DIV_W'(idx_w[TABLE_DEPTH]);
				end
			end
			S_DIVIDX: begin
				if (div_rsp.done && !beyond) begin
					div_req.start    = 1'b1;
					div_req.dividend = {div_rsp.rem, FRAC_ZERO};
				end
			end
			S_UVL: begin
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = {col_inc, FRAC_ZERO};
				end
			end
			S_UVR: begin
				div_req.divisor = rows_eff;
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = {row_q, FRAC_ZERO};
				end
			end
			S_UVT: begin
				div_req.divisor = rows_eff;
				if (div_rsp.done) begin
					div_req.start    = 1'b1;
					div_req.dividend = {row_inc, FRAC_ZERO};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			inj_q       <= 1'b0;
			key_q       <= '0;
			status_q    <= ST_FOUND;
			col_q       <= '0;
			row_q       <= '0;
			uvl_q       <= '0;
			uvr_q       <= '0;
			uvt_q       <= '0;
			uvb_q       <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			inj_q <= 1'b0;
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && (cmd.action == ACT_LOOKUP)) begin
						key_q    <= cmd.codepoint;
						inj_q    <= 1'b1;
						status_q <= ST_FOUND;
						uvl_q    <= '0;
						uvr_q    <= '0;
						uvt_q    <= '0;
						uvb_q    <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (tok_w[TABLE_DEPTH].valid) begin
						if (tok_w[TABLE_DEPTH].found) begin
							state_q <= S_DIVIDX;
						end else begin
							status_q <= ST_NOT_FOUND;
							state_q  <= S_OUT;
						end
					end
				end
				S_DIVIDX: begin
					if (div_rsp.done) begin
						col_q <= div_rsp.rem;
						row_q <= div_rsp.quot[REG9_W-1:0];
						if (beyond) begin
							status_q <= ST_BEYOND_GRID;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_UVL;
						end
					end
				end
				S_UVL: begin
					if (div_rsp.done) begin
						uvl_q   <= div_rsp.quot[UV_W-1:0];
						state_q <= S_UVR;
					end
				end
				S_UVR: begin
					if (div_rsp.done) begin
						uvr_q   <= div_rsp.quot[UV_W-1:0];
						state_q <= S_UVT;
					end
				end
				S_UVT: begin
					if (div_rsp.done) begin
						uvt_q   <= UV_ONE - div_rsp.quot[UV_W-1:0];
						state_q <= S_UVB;
					end
				end
				S_UVB: begin
					if (div_rsp.done) begin
						uvb_q   <= UV_ONE - div_rsp.quot[UV_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// wait for a free result register; a failed lookup carries zeros
					if (!res_valid_q || res_ready) begin
						res_q.status     <= status_q;
						res_q.uv_left    <= uvl_q;
						res_q.uv_right   <= uvr_q;
						res_q.uv_top     <= uvt_q;
						res_q.uv_bottom  <= uvb_q;
						res_q.out_width  <= (status_q == ST_FOUND) ? width_eff : '0;
						res_q.out_height <= (status_q == ST_FOUND) ? height_eff : '0;
						res_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_tok_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_w[TABLE_DEPTH].valid |-> (state_q == S_SCAN))
		else $error("search token left the chain outside a scan");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIVIDX || state_q == S_UVL || state_q == S_UVR ||
			state_q == S_UVT || state_q == S_UVB))
		else $error("divider finished with nobody waiting");
	a_out_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && (!res_valid_q || res_ready)) |=> (res_valid && state_q == S_IDLE))
		else $error("result not handed to the output register");

endmodule

/* sim/font_atlas_glyph_lookup_top_tb.sv */
// Self-checking testbench of the font atlas glyph lookup: table loads, lookups, status and UVs.
`timescale 1ns / 100ps

module font_atlas_glyph_lookup_top_tb;

	import fag_pkg::*;

	localparam int TABLE_DEPTH   = 256;
	// a lookup walks the whole chain then runs five serial divisions
	localparam int SETTLE_CYCLES = 2 * (TABLE_DEPTH + 133);
	localparam int CYCLE_LIMIT   = 4_000_000;
	localparam int HOLD_CYCLES   = 3000;
	localparam int MAX_REPORTS   = 40;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_ready;
	cmd_item_t             cmd       = '0;
	logic                  res_valid;
	logic                  res_ready = 1'b0;
	res_item_t             res;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	font_atlas_glyph_lookup_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the block: codepoint table and registers as written.
	logic [CP_W-1:0]   glyph_codes [TABLE_DEPTH];
	logic [REG9_W-1:0] columns_q = 9'd1;
	logic [REG9_W-1:0] rows_q    = 9'd1;
	logic [REG9_W-1:0] count_q   = 9'd0;
	logic [SIZE_W-1:0] width_q   = 13'd1;
	logic [SIZE_W-1:0] height_q  = 13'd1;

	res_item_t expected_glyphs[$];
	res_item_t want;

	int errors       = 0;
	int reports      = 0;
	int items_sent   = 0;
	int lookups_sent = 0;
	int status_seen [4];
	int cycle_count  = 0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// long result hold-off: the test flips hold_go, the receiver counts it out
	logic hold_go   = 1'b0;
	logic hold_seen = 1'b0;
	int   hold_len  = 0;
	int   hold_left = 0;

	function automatic logic [63:0] uv_frac(input logic [63:0] num, input logic [63:0] den);
		return (num << UV_FRAC_BITS) / den;
	endfunction

	// First match below the (saturated) glyph count, then slot -> column/row -> UVs.
	function automatic res_item_t lookup_glyph(input logic [CP_W-1:0] code);
		res_item_t   r;
		int unsigned n, idx, cols, rows, col, row;
		bit          hit;
		logic [63:0] one, q;
		r   = '0;
		hit = 1'b0;
		idx = 0;
		n   = (count_q > TABLE_DEPTH) ? TABLE_DEPTH : count_q;
		for (int unsigned i = 0; i < n; i++) begin
			if (!hit && glyph_codes[i] == code) begin
				hit = 1'b1;
				idx = i;
			end
		end
		if (!hit) begin
			r.status = ST_NOT_FOUND;
			return r;
		end
		cols = (columns_q == 0) ? 1 : columns_q;
		rows = (rows_q == 0) ? 1 : rows_q;
		col  = idx % cols;
		row  = idx / cols;
		if (row >= rows) begin
			r.status = ST_BEYOND_GRID;
			return r;
		end
		one        = 64'd1 << UV_FRAC_BITS;
		r.status   = ST_FOUND;
		q          = uv_frac(col, cols);
		r.uv_left  = q[UV_W-1:0];
		q          = uv_frac(col + 1, cols);
		r.uv_right = q[UV_W-1:0];
		q          = one - uv_frac(row, rows);
		r.uv_top   = q[UV_W-1:0];
		q          = one - uv_frac(row + 1, rows);
		r.uv_bottom = q[UV_W-1:0];
		r.out_width  = (width_q == 0) ? 13'd1 : width_q;
		r.out_height = (height_q == 0) ? 13'd1 : height_q;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] got);
		if (got !== exp) begin
			errors++;
			if (reports < MAX_REPORTS) begin
				reports++;
				$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, got);
			end
		end
	endtask

	// Result side: check each accepted item, then pick next cycle's ready.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_glyphs.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("%0t: result item with nothing expected, expected none, got status %0d",
						$time, res.status);
				end
			end else begin
				want = expected_glyphs.pop_front();
				check_field("status",     want.status,     res.status);
				check_field("uv_left",    want.uv_left,    res.uv_left);
				check_field("uv_right",   want.uv_right,   res.uv_right);
				check_field("uv_top",     want.uv_top,     res.uv_top);
				check_field("uv_bottom",  want.uv_bottom,  res.uv_bottom);
				check_field("out_width",  want.out_width,  res.out_width);
				check_field("out_height", want.out_height, res.out_height);
				status_seen[want.status]++;
			end
		end
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			res_ready <= 1'b0;
			hold_left--;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[font_atlas_glyph_lookup_top] ERROR");
			$finish;
		end
	end

	// Offer one item, optionally after a random gap; valid stays up once accepted.
	task automatic send_item(input cmd_item_t it);
		int gaps;
		gaps = 0;
		while (gaps < 40 && $urandom_range(99) < send_idle_pct)
			gaps++;
		if (gaps > 0) begin
			cmd_valid <= 1'b0;
			repeat (gaps) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= it;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		items_sent++;
		if (it.action == ACT_LOAD) begin
			glyph_codes[it.slot] = it.codepoint;
		end else begin
			lookups_sent++;
			expected_glyphs.push_back(lookup_glyph(it.codepoint));
		end
	endtask

	task automatic send_load(input logic [SLOT_W-1:0] slot, input logic [CP_W-1:0] code);
		cmd_item_t it;
		it.action    = ACT_LOAD;
		it.slot      = slot;
		it.codepoint = code;
		send_item(it);
	endtask

	// slot is a don't-care on lookups, so it carries noise
	task automatic send_lookup(input logic [CP_W-1:0] code);
		cmd_item_t it;
		it.action    = ACT_LOOKUP;
		it.slot      = SLOT_W'($urandom());
		it.codepoint = code;
		send_item(it);
	endtask

	// Drop valid and wait for every expected result; optionally let the block go quiet.
	task automatic drain(input bit settle);
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (expected_glyphs.size() != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_GRID_COLUMNS: columns_q = data[REG9_W-1:0];
			CFG_GRID_ROWS:    rows_q    = data[REG9_W-1:0];
			CFG_GLYPH_COUNT:  count_q   = data[REG9_W-1:0];
			CFG_GLYPH_WIDTH:  width_q   = data;
			CFG_GLYPH_HEIGHT: height_q  = data;
			default: ;
		endcase
	endtask

	// All five registers plus a write to an index past the list, which must be ignored.
	task automatic set_config(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows,
			input logic [CFG_DATA_W-1:0] count, input logic [CFG_DATA_W-1:0] width,
			input logic [CFG_DATA_W-1:0] height);
		drain(1'b1);
		cfg_write(CFG_GRID_COLUMNS, cols);
		cfg_write(CFG_GRID_ROWS, rows);
		cfg_write(CFG_GLYPH_COUNT, count);
		cfg_write(CFG_GLYPH_WIDTH, width);
		cfg_write(CFG_GLYPH_HEIGHT, height);
		cfg_write(CFG_IDX_W'($urandom_range(CFG_GLYPH_HEIGHT + 1, (1 << CFG_IDX_W) - 1)),
			CFG_DATA_W'($urandom()));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		logic [REG9_W-1:0] v;
		case ($urandom_range(7))
			0:       v = 9'd0;
			1:       v = 9'd1;
			2:       v = 9'd256;
			3:       v = 9'd511;
			4, 5:    v = REG9_W'($urandom_range(1, 32));
			default: v = REG9_W'($urandom_range(1, 256));
		endcase
		// upper data bits are outside the register and must be dropped
		return {($urandom_range(3) == 0) ? 4'($urandom()) : 4'd0, v};
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_count();
		case ($urandom_range(5))
			0:       return 13'd0;
			1:       return 13'd511;
			2, 3:    return 13'd256;
			default: return CFG_DATA_W'($urandom_range(1, 256));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_size();
		case ($urandom_range(5))
			0:       return 13'd0;
			1:       return 13'd1;
			2:       return 13'd4096;
			3:       return 13'd8191;
			default: return CFG_DATA_W'($urandom_range(1, 4096));
		endcase
	endfunction

	// Mostly lookups of codepoints that sit in the searched range, plus loads and misses.
	function automatic cmd_item_t random_item();
		cmd_item_t   it;
		int unsigned n, pick;
		n    = (count_q > TABLE_DEPTH) ? TABLE_DEPTH : count_q;
		pick = $urandom_range(99);
		it.slot = SLOT_W'($urandom());
		if (pick < 30) begin
			it.action = ACT_LOAD;
			case ($urandom_range(9))
				0:       it.codepoint = 21'h000000;
				1:       it.codepoint = 21'h1FFFFF;
				2:       it.codepoint = 21'h10FFFF;
				3, 4, 5: it.codepoint = glyph_codes[$urandom_range(TABLE_DEPTH - 1)];
				default: it.codepoint = CP_W'($urandom());
			endcase
		end else if (pick < 85) begin
			it.action    = ACT_LOOKUP;
			it.codepoint = glyph_codes[$urandom_range((n == 0) ? TABLE_DEPTH - 1 : n - 1)];
		end else begin
			it.action    = ACT_LOOKUP;
			it.codepoint = CP_W'($urandom());
		end
		return it;
	endfunction

	// Reset values: nothing is searched, so every lookup misses.
	task automatic test_reset_lookups();
		send_lookup(21'h000000);
		send_lookup(21'h1FFFFF);
	endtask

	// Every slot gets a distinct code (odd multiplier) so no lookup touches an unwritten entry.
	task automatic fill_table();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_load(SLOT_W'(i), CP_W'(i * 21'h01F3D + 5));
	endtask

	task automatic test_directed_lookups();
		send_load(8'd0, 21'h000000);
		send_load(8'd255, 21'h1FFFFF);
		send_load(8'd10, 21'h10FFFF);
		send_load(8'd200, 21'h10FFFF);
		set_config(13'd16, 13'd16, 13'd256, 13'd4096, 13'd4096);
		send_lookup(21'h000000);          // top-left corner
		send_lookup(21'h1FFFFF);          // bottom-right corner
		send_lookup(21'h10FFFF);          // duplicate: the lower slot wins
		send_lookup(glyph_codes[100]);
		send_lookup(21'h0ABCDE);
		// only four rows: slot 100 lands in row 6
		set_config(13'd16, 13'd4, 13'd256, 13'd1, 13'd1);
		send_lookup(glyph_codes[100]);
		send_lookup(21'h10FFFF);
		// zero dimensions and sizes read as one
		set_config(13'd0, 13'd0, 13'd256, 13'd0, 13'd0);
		send_lookup(21'h000000);
		send_lookup(21'h10FFFF);
		// above range: grid used as written, count saturates at the table depth
		set_config(13'd511, 13'd511, 13'd511, 13'd8191, 13'd8191);
		send_lookup(21'h1FFFFF);
		send_lookup(glyph_codes[128]);
		// short search range: slot 150 is not searched
		set_config(13'd256, 13'd256, 13'd100, 13'd4096, 13'd1);
		send_lookup(21'h10FFFF);
		send_lookup(glyph_codes[150]);
		// a single column: row equals slot
		set_config(13'd1, 13'd256, 13'd256, 13'd1, 13'd4096);
		send_lookup(21'h1FFFFF);
		send_lookup(glyph_codes[1]);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int phases);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int p = 0; p < phases; p++) begin
			set_config(pick_dim(), pick_dim(), pick_count(), pick_size(), pick_size());
			repeat (80) send_item(random_item());
		end
	endtask

	// Results held off for a long stretch while items keep coming: the input must stall.
	task automatic test_result_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(13'd16, 13'd16, 13'd256, 13'd64, 13'd32);
		hold_len <= HOLD_CYCLES;
		hold_go  <= ~hold_go;
		repeat (40) send_item(random_item());
	endtask

	// Sender goes quiet until every result is back, then resumes.
	task automatic test_sender_pause();
		send_idle_pct = 10;
		recv_idle_pct = 10;
		set_config(13'd32, 13'd8, 13'd256, 13'd12, 13'd24);
		repeat (30) send_item(random_item());
		drain(1'b0);
		repeat (30) send_item(random_item());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_lookups();
		fill_table();
		test_directed_lookups();
		test_random_traffic(26, 58, 4);
		test_random_traffic(58, 26, 4);
		test_random_traffic(0, 0, 3);
		test_result_backpressure();
		test_sender_pause();

		drain(1'b1);
		$display("Sent %0d items (%0d lookups): reset state, table fill, directed corners, random mix",
			items_sent, lookups_sent);
		$display("Checked %0d found, %0d not in table, %0d beyond grid, under stalls and hold-off",
			status_seen[ST_FOUND], status_seen[ST_NOT_FOUND], status_seen[ST_BEYOND_GRID]);
		if (errors == 0) begin
			$display("[font_atlas_glyph_lookup_top] OK");
		end else begin
			$display("[font_atlas_glyph_lookup_top] ERROR");
		end
		$finish;
	end

endmodule
